### src/tlbh_pkg.sv
// shared types and constants for the two-level tlb
`default_nettype none
package tlbh_pkg;
  localparam int VPAGE_W = 36;
  localparam int PPAGE_W = 20;
  localparam int INSTR_L1_LINES_DEF = 16;
  localparam int DATA_L1_LINES_DEF = 16;
  localparam int SHARED_L2_LINES_DEF = 64;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_REFILL = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam logic [1:0] TGT_IL1 = 2'd0;
  localparam logic [1:0] TGT_DL1 = 2'd1;
  localparam logic [1:0] TGT_L2  = 2'd2;

  localparam logic [1:0] LVL_L1   = 2'd0;
  localparam logic [1:0] LVL_L2   = 2'd1;
  localparam logic [1:0] LVL_MISS = 2'd2;
  localparam logic [1:0] LVL_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic               access_kind;
    logic [VPAGE_W-1:0] virt_page;
    logic [PPAGE_W-1:0] walk_page;
    logic [1:0]         flush_target;
  } tlbh_req_t;
endpackage
`default_nettype wire

### src/two_level_tlb_hierarchy.sv
// top level of the two-level tlb: request queue in front of the tlb engine
// a lookup passes the engine's read and result states; a refill or flush also passes an update state
// the engine takes no new request until the result of the last one has been handshaked
// the two-entry queue takes up to two further requests while the engine works
// flush clears a whole store through its valid flops
// reset (synchronous, active low) invalidates every entry and empties the queue
`default_nettype none
module two_level_tlb_hierarchy
  import tlbh_pkg::*;
#(
  parameter int INSTR_L1_LINES  = INSTR_L1_LINES_DEF,
  parameter int DATA_L1_LINES   = DATA_L1_LINES_DEF,
  parameter int SHARED_L2_LINES = SHARED_L2_LINES_DEF
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic               in_access_kind,
  input  wire logic [VPAGE_W-1:0] in_virt_page,
  input  wire logic [PPAGE_W-1:0] in_walk_page,
  input  wire logic [1:0]         in_flush_target,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_hit_level,
  output logic [PPAGE_W-1:0]      out_phys_page
);
  tlbh_req_t in_req, q_req;
  logic      q_valid, q_ready;

  assign in_req = '{command: in_command, access_kind: in_access_kind,
                    virt_page: in_virt_page, walk_page: in_walk_page,
                    flush_target: in_flush_target};

  tlbh_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  tlbh_engine #(
    .INSTR_L1_LINES(INSTR_L1_LINES),
    .DATA_L1_LINES(DATA_L1_LINES),
    .SHARED_L2_LINES(SHARED_L2_LINES)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .res_valid(out_valid), .res_ready(out_ready),
    .res_level(out_hit_level), .res_page(out_phys_page)
  );
endmodule
`default_nettype wire

### src/tlbh_queue.sv
// two-entry request queue between the front end and the tlb engine
`default_nettype none
module tlbh_queue
  import tlbh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  tlbh_req_t      wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output tlbh_req_t      rd_data
);
  tlbh_req_t  slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= wr_data;
        wp_r <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("pop lost");
endmodule
`default_nettype wire

### src/tlbh_engine.sv
// tlb engine: lookup, refill and flush over the three translation stores
`default_nettype none
module tlbh_engine
  import tlbh_pkg::*;
#(
  parameter int INSTR_L1_LINES  = INSTR_L1_LINES_DEF,
  parameter int DATA_L1_LINES   = DATA_L1_LINES_DEF,
  parameter int SHARED_L2_LINES = SHARED_L2_LINES_DEF
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  tlbh_req_t              req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [1:0]             res_level,
  output logic [PPAGE_W-1:0]     res_page
);
  localparam int IB = $clog2(INSTR_L1_LINES);
  localparam int DB = $clog2(DATA_L1_LINES);
  localparam int LB = $clog2(SHARED_L2_LINES);
  localparam int IT = VPAGE_W - IB;
  localparam int DT = VPAGE_W - DB;
  localparam int LT = VPAGE_W - LB;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_CLEAR, S_OUT} state_t;

  // tag and page arrays read through registered ports; valid bits in flops
  logic [IT-1:0]      itag_m [INSTR_L1_LINES];
  logic [PPAGE_W-1:0] ipg_m  [INSTR_L1_LINES];
  logic [DT-1:0]      dtag_m [DATA_L1_LINES];
  logic [PPAGE_W-1:0] dpg_m  [DATA_L1_LINES];
  logic [LT-1:0]      ltag_m [SHARED_L2_LINES];
  logic [PPAGE_W-1:0] lpg_m  [SHARED_L2_LINES];
  logic [INSTR_L1_LINES-1:0]  iv_r;
  logic [DATA_L1_LINES-1:0]   dv_r;
  logic [SHARED_L2_LINES-1:0] lv_r;

  state_t             state_r;
  tlbh_req_t          q_r;
  logic [IT-1:0]      itag_rd_r;
  logic [PPAGE_W-1:0] ipg_rd_r;
  logic [DT-1:0]      dtag_rd_r;
  logic [PPAGE_W-1:0] dpg_rd_r;
  logic [LT-1:0]      ltag_rd_r;
  logic [PPAGE_W-1:0] lpg_rd_r;
  logic [1:0]         lvl_r;
  logic [PPAGE_W-1:0] pg_r;
  logic               ev_r;
  logic [VPAGE_W-1:0] ovp_r;

  logic [IB-1:0] iidx;
  logic [DB-1:0] didx;
  logic [LB-1:0] lidx;
  logic [VPAGE_W-1:0] ovp;
  logic [IB-1:0] oiidx;
  logic [DB-1:0] odidx;
  logic          kd;
  logic          l1_hit, l2_hit;

  assign iidx = q_r.virt_page[IB-1:0];
  assign didx = q_r.virt_page[DB-1:0];
  assign lidx = q_r.virt_page[LB-1:0];
  assign kd   = q_r.access_kind;
  assign ovp   = {ltag_rd_r, lidx};
  assign oiidx = ovp_r[IB-1:0];
  assign odidx = ovp_r[DB-1:0];
  assign l1_hit = kd ? (dv_r[didx] && dtag_rd_r == q_r.virt_page[VPAGE_W-1:DB])
                     : (iv_r[iidx] && itag_rd_r == q_r.virt_page[VPAGE_W-1:IB]);
  assign l2_hit = lv_r[lidx] && ltag_rd_r == q_r.virt_page[VPAGE_W-1:LB];

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_level = lvl_r;
  assign res_page  = pg_r;

  // registered read ports; the other-l1 probe for eviction reuses them
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      itag_rd_r <= itag_m[req.virt_page[IB-1:0]];
      ipg_rd_r  <= ipg_m[req.virt_page[IB-1:0]];
      dtag_rd_r <= dtag_m[req.virt_page[DB-1:0]];
      dpg_rd_r  <= dpg_m[req.virt_page[DB-1:0]];
      ltag_rd_r <= ltag_m[req.virt_page[LB-1:0]];
      lpg_rd_r  <= lpg_m[req.virt_page[LB-1:0]];
    end else if (state_r == S_READ) begin
      itag_rd_r <= itag_m[ovp[IB-1:0]];
      dtag_rd_r <= dtag_m[ovp[DB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iv_r <= '0;
      dv_r <= '0;
      lv_r <= '0;
      lvl_r <= LVL_DONE;
      pg_r  <= '0;
      ev_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (req_valid) begin
          q_r <= req;
          state_r <= S_READ;
        end
        S_READ: begin
          lvl_r <= LVL_DONE;
          pg_r  <= '0;
          ev_r  <= lv_r[lidx];
          ovp_r <= ovp;
          case (q_r.command)
            CMD_LOOKUP: begin
              if (l1_hit) begin
                lvl_r <= LVL_L1;
                pg_r  <= kd ? dpg_rd_r : ipg_rd_r;
              end else if (l2_hit) begin
                lvl_r <= LVL_L2;
                pg_r  <= lpg_rd_r;
                if (kd) begin
                  dv_r[didx] <= 1'b1;
                  dtag_m[didx] <= q_r.virt_page[VPAGE_W-1:DB];
                  dpg_m[didx]  <= lpg_rd_r;
                end else begin
                  iv_r[iidx] <= 1'b1;
                  itag_m[iidx] <= q_r.virt_page[VPAGE_W-1:IB];
                  ipg_m[iidx]  <= lpg_rd_r;
                end
              end else begin
                lvl_r <= LVL_MISS;
              end
              state_r <= S_OUT;
            end
            CMD_REFILL: state_r <= S_EXEC;
            CMD_FLUSH:  state_r <= S_CLEAR;
            default:    state_r <= S_OUT;
          endcase
        end
        S_EXEC: begin
          // drop the other l1's copy of the evicted l2 entry, then fill both
          if (ev_r) begin
            if (kd) begin
              if (iv_r[oiidx] && itag_rd_r == ovp_r[VPAGE_W-1:IB])
                iv_r[oiidx] <= 1'b0;
            end else begin
              if (dv_r[odidx] && dtag_rd_r == ovp_r[VPAGE_W-1:DB])
                dv_r[odidx] <= 1'b0;
            end
          end
          lv_r[lidx] <= 1'b1;
          ltag_m[lidx] <= q_r.virt_page[VPAGE_W-1:LB];
          lpg_m[lidx]  <= q_r.walk_page;
          if (kd) begin
            dv_r[didx] <= 1'b1;
            dtag_m[didx] <= q_r.virt_page[VPAGE_W-1:DB];
            dpg_m[didx]  <= q_r.walk_page;
          end else begin
            iv_r[iidx] <= 1'b1;
            itag_m[iidx] <= q_r.virt_page[VPAGE_W-1:IB];
            ipg_m[iidx]  <= q_r.walk_page;
          end
          state_r <= S_OUT;
        end
        S_CLEAR: begin
          case (q_r.flush_target)
            TGT_IL1: iv_r <= '0;
            TGT_DL1: dv_r <= '0;
            TGT_L2:  lv_r <= '0;
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid && $stable(res_level) && $stable(res_page))
    else $error("result changed while stalled");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res_level == LVL_MISS || res_level == LVL_DONE)) |-> res_page == '0)
    else $error("page not zero on miss or done");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_ready |-> !res_valid) else $error("accept while result pending");
endmodule
`default_nettype wire

### bench/tb_top.sv
// testbench for the two-level tlb: queued request driver, result monitor and translation predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbh_pkg::*;

  localparam int IL1_N = INSTR_L1_LINES_DEF;
  localparam int DL1_N = DATA_L1_LINES_DEF;
  localparam int L2_N  = SHARED_L2_LINES_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic               vld;
    logic [VPAGE_W-1:0] tag;
    logic [PPAGE_W-1:0] page;
  } tlb_line_t;

  typedef struct {
    logic [1:0]         level;
    logic [PPAGE_W-1:0] page;
  } xlate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic in_access_kind = 1'b0;
  logic [VPAGE_W-1:0] in_virt_page = '0;
  logic [PPAGE_W-1:0] in_walk_page = '0;
  logic [1:0] in_flush_target = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_hit_level;
  logic [PPAGE_W-1:0] out_phys_page;

  tlb_line_t il1_model [IL1_N];
  tlb_line_t dl1_model [DL1_N];
  tlb_line_t l2_model [L2_N];

  tlbh_req_t pending_reqs[$];
  xlate_t expected_xlates[$];
  int send_idle_pct = 37;
  int recv_idle_pct = 65;
  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  bit driving_done = 1'b0;

  always #2 clk = ~clk;

  two_level_tlb_hierarchy u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_access_kind(in_access_kind),
    .in_virt_page(in_virt_page), .in_walk_page(in_walk_page),
    .in_flush_target(in_flush_target),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit_level(out_hit_level), .out_phys_page(out_phys_page)
  );

  function automatic xlate_t predict_xlate(tlbh_req_t r);
    xlate_t res;
    int l1n;
    int idx;
    int oidx;
    logic [VPAGE_W-1:0] ovp;
    tlb_line_t line;
    res.level = LVL_DONE;
    res.page = '0;
    l1n = r.access_kind ? DL1_N : IL1_N;
    idx = int'(r.virt_page % l1n);
    line = r.access_kind ? dl1_model[idx] : il1_model[idx];
    case (r.command)
      CMD_LOOKUP: begin
        if (line.vld && line.tag == r.virt_page / l1n) begin
          res.level = LVL_L1;
          res.page = line.page;
        end else if (l2_model[r.virt_page % L2_N].vld &&
                     l2_model[r.virt_page % L2_N].tag == r.virt_page / L2_N) begin
          res.level = LVL_L2;
          res.page = l2_model[r.virt_page % L2_N].page;
          line = '{1'b1, VPAGE_W'(r.virt_page / l1n), res.page};
          if (r.access_kind) dl1_model[idx] = line;
          else il1_model[idx] = line;
        end else begin
          res.level = LVL_MISS;
        end
      end
      CMD_REFILL: begin
        oidx = int'(r.virt_page % L2_N);
        if (l2_model[oidx].vld) begin
          ovp = VPAGE_W'(l2_model[oidx].tag * L2_N + oidx);
          // the other l1 loses its copy of the evicted page
          if (r.access_kind) begin
            if (il1_model[ovp % IL1_N].vld && il1_model[ovp % IL1_N].tag == ovp / IL1_N)
              il1_model[ovp % IL1_N].vld = 1'b0;
          end else begin
            if (dl1_model[ovp % DL1_N].vld && dl1_model[ovp % DL1_N].tag == ovp / DL1_N)
              dl1_model[ovp % DL1_N].vld = 1'b0;
          end
        end
        l2_model[oidx] = '{1'b1, VPAGE_W'(r.virt_page / L2_N), r.walk_page};
        line = '{1'b1, VPAGE_W'(r.virt_page / l1n), r.walk_page};
        if (r.access_kind) dl1_model[idx] = line;
        else il1_model[idx] = line;
      end
      CMD_FLUSH: begin
        if (r.flush_target == TGT_IL1) foreach (il1_model[i]) il1_model[i] = '{1'b0, '0, '0};
        if (r.flush_target == TGT_DL1) foreach (dl1_model[i]) dl1_model[i] = '{1'b0, '0, '0};
        if (r.flush_target == TGT_L2) foreach (l2_model[i]) l2_model[i] = '{1'b0, '0, '0};
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic tlbh_req_t make_req(logic [1:0] cmd, logic kind,
                                         logic [VPAGE_W-1:0] vp, logic [PPAGE_W-1:0] wp,
                                         logic [1:0] tgt);
    tlbh_req_t r;
    r.command = cmd;
    r.access_kind = kind;
    r.virt_page = vp;
    r.walk_page = wp;
    r.flush_target = tgt;
    return r;
  endfunction

  // driver: a new request once the previous one was taken at the last rising edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tlbh_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_command <= r.command;
        in_access_kind <= r.access_kind;
        in_virt_page <= r.virt_page;
        in_walk_page <= r.walk_page;
        in_flush_target <= r.flush_target;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on acceptance, check results
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && in_ready) begin
        expected_xlates.push_back(predict_xlate(make_req(in_command, in_access_kind,
                                  in_virt_page, in_walk_page, in_flush_target)));
      end
      if (out_valid && out_ready) begin
        if (expected_xlates.size() == 0) begin
          $display("%0t: unexpected result level %0d page %h", $time, out_hit_level,
                   out_phys_page);
          errors++;
        end else begin
          xlate_t e;
          e = expected_xlates.pop_front();
          if (e.level !== out_hit_level) begin
            $display("%0t: hit_level expected %0d actual %0d", $time, e.level, out_hit_level);
            errors++;
          end
          if (e.page !== out_phys_page) begin
            $display("%0t: phys_page expected %h actual %h", $time, e.page, out_phys_page);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** two_level_tlb_hierarchy: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_random(int n);
    logic [VPAGE_W-1:0] vp;
    logic kind;
    int pick;
    for (int i = 0; i < n; i++) begin
      // small page pool so lines collide and hits happen
      pick = $urandom_range(99);
      vp = VPAGE_W'({$urandom, $urandom});
      if (pick < 80) vp = VPAGE_W'(($urandom_range(3) << 6) | $urandom_range(L2_N - 1));
      if (pick < 80 && $urandom_range(9) == 0) vp[VPAGE_W-1 -: 4] = 4'($urandom);
      kind = 1'($urandom);
      if ($urandom_range(99) < 45) begin
        pending_reqs.push_back(make_req(CMD_LOOKUP, kind, vp, PPAGE_W'($urandom),
                                        2'($urandom)));
      end else if ($urandom_range(99) < 85) begin
        // walk then lookup again, the usual miss sequence
        pending_reqs.push_back(make_req(CMD_LOOKUP, kind, vp, PPAGE_W'($urandom),
                                        2'($urandom)));
        pending_reqs.push_back(make_req(CMD_REFILL, kind, vp, PPAGE_W'($urandom),
                                        2'($urandom)));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 1'($urandom), vp, PPAGE_W'($urandom),
                                        2'($urandom)));
        i += 2;
      end else if ($urandom_range(99) < 70) begin
        pending_reqs.push_back(make_req(CMD_REFILL, kind, vp, PPAGE_W'($urandom),
                                        2'($urandom)));
      end else begin
        pending_reqs.push_back(make_req(2'($urandom_range(2, 3)), kind, vp,
                                        PPAGE_W'($urandom), 2'($urandom)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_xlates.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [VPAGE_W-1:0] vmax;
    logic [PPAGE_W-1:0] pmax;
    vmax = '1;
    pmax = '1;
    for (int i = 0; i < IL1_N; i++) il1_model[i] = '{1'b0, '0, '0};
    for (int i = 0; i < DL1_N; i++) dl1_model[i] = '{1'b0, '0, '0};
    for (int i = 0; i < L2_N; i++) l2_model[i] = '{1'b0, '0, '0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b0, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_REFILL, 1'b0, '0, pmax, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b0, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b1, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b1, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_REFILL, 1'b1, vmax, 20'h5a5a5, TGT_DL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b1, vmax, '0, TGT_DL1));
    // same l2 line, evicts and drops the data copy
    pending_reqs.push_back(make_req(CMD_REFILL, 1'b0, vmax, 20'h12345, TGT_L2));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b1, vmax, '0, TGT_L2));
    pending_reqs.push_back(make_req(CMD_REFILL, 1'b1, 36'h40, pmax, TGT_L2));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b0, '0, '0, TGT_L2));
    pending_reqs.push_back(make_req(CMD_REFILL, 1'b0, '0, 20'h1, TGT_L2));
    pending_reqs.push_back(make_req(CMD_FLUSH, 1'b0, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b0, '0, '0, TGT_IL1));
    pending_reqs.push_back(make_req(CMD_FLUSH, 1'b1, vmax, pmax, TGT_DL1));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b1, '0, '0, TGT_DL1));
    pending_reqs.push_back(make_req(CMD_FLUSH, 1'b0, '0, '0, 2'd3));
    pending_reqs.push_back(make_req(2'd3, 1'b1, vmax, pmax, 2'd3));
    pending_reqs.push_back(make_req(CMD_FLUSH, 1'b0, '0, '0, TGT_L2));
    pending_reqs.push_back(make_req(CMD_LOOKUP, 1'b0, 36'h40, '0, TGT_L2));

    queue_random(400);
    wait_drained();
    send_idle_pct = 65;
    recv_idle_pct = 37;
    queue_random(400);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(430);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_xlates.size() == 0) begin
      $display("** two_level_tlb_hierarchy: PASSED **");
    end else begin
      $display("** two_level_tlb_hierarchy: FAILED **");
    end
    $finish;
  end
endmodule
